>>> sv/sphf_pkg.sv
// Shared types, constants and saturation helpers of the SPH pressure force unit.
package sphf_pkg;

	// Number format.
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int ACC_W     = 48;
	localparam int PROD_W    = 64;
	localparam int DIV_W     = 48;
	localparam int MAG_W     = 80;

	// Softening constant 0.01 in Q format, rounded.
	localparam logic [31:0] C001 = 32'(((1 << FRAC_BITS) + 50) / 100);

	// Register reset values.
	localparam logic [30:0] MASS_RST    = 31'(1 << FRAC_BITS);
	localparam logic [30:0] SUPPORT_RST = 31'(1 << FRAC_BITS);
	localparam logic [30:0] VISC_RST    = 31'd0;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MASS    = 2'd0;
	localparam logic [1:0] CFG_SUPPORT = 2'd1;
	localparam logic [1:0] CFG_VISC    = 2'd2;

	// Opcode of an input item.
	localparam logic OP_BEGIN = 1'b0;

	// Operand pair for the shared multiplier.
	typedef enum logic [3:0] {
		MS_NONE, MS_SQ, MS_CGX, MS_CGY, MS_RDX, MS_RDY, MS_HH, MS_TC,
		MS_HD, MS_MM, MS_VM, MS_M2, MS_SXL, MS_SXH, MS_SYL, MS_SYH
	} mul_sel_t;

	// Destination of a result.
	typedef enum logic [4:0] {
		WB_NONE, WB_OWN, WB_PB, WB_SX, WB_SY, WB_DX, WB_DY, WB_HH, WB_DEN,
		WB_HD, WB_MU, WB_MM, WB_VM, WB_FAC, WB_M2, WB_PL, WB_FX, WB_FY
	} wb_sel_t;

	// Operand pair for the shared divider.
	typedef enum logic [1:0] {
		DS_NONE, DS_P, DS_MU, DS_FAC
	} div_sel_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_SQ_MUL, ST_P_DIV, ST_P_WAIT,
		ST_GX_MUL, ST_GX_WB, ST_GY_MUL, ST_GY_WB,
		ST_DX_MUL, ST_DX_WB, ST_DY_MUL, ST_DY_WB, ST_DOT,
		ST_HH_MUL, ST_HH_WB, ST_C_MUL, ST_C_WB, ST_HD_MUL, ST_HD_WB,
		ST_MU_DIV, ST_MU_WAIT, ST_MM_MUL, ST_MM_WB, ST_VM_MUL, ST_VM_WB,
		ST_FAC_DIV, ST_FAC_WAIT, ST_END, ST_M2_MUL, ST_M2_WB,
		ST_SXL_MUL, ST_SXL_WB, ST_SXH_MUL, ST_SXH_WB,
		ST_SYL_MUL, ST_SYL_WB, ST_SYH_MUL, ST_SYH_WB
	} state_t;

	typedef struct packed {
		logic     load;
		mul_sel_t mul;
		div_sel_t div;
		wb_sel_t  wb;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic last;
		logic dot_neg;
		logic div_done;
		logic out_busy;
	} status_t;

	// Saturate a 33-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Saturate a 49-bit signed value to 48 bits.
	function automatic logic signed [47:0] sat49(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) begin
			r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	// Apply a sign to a magnitude and saturate to 32 bits.
	function automatic logic signed [31:0] sat_mag(input logic [MAG_W-1:0] m,
		input logic neg);
		logic big;
		logic signed [31:0] r;
		big = |m[MAG_W-1:32];
		if (neg) begin
			r = (big || (m[31] && |m[30:0])) ? {1'b1, 31'd0} : -m[31:0];
		end else begin
			r = (big || m[31]) ? {1'b0, {31{1'b1}}} : m[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		return v[47] ? -v : v;
	endfunction

endpackage

>>> sv/sphf_div.sv
// Radix-2 restoring divider: signed Q numerator over a positive divisor, saturated.
module sphf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [31:0]         num,
	input  logic [sphf_pkg::DIV_W-1:0] den,
	output logic                       done,
	output logic signed [31:0]         quot
);
	import sphf_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dq_q;
	logic [DIV_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             ge;

	// One quotient bit per cycle.
	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and shifting dividend/quotient word.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= {mag32(num), 16'd0};
			den_q <= den;
			neg_q <= num[31];
		end else if (run_q) begin
			rem_q <= ge ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sat_mag({32'd0, dq_q}, neg_q);

endmodule

>>> sv/sphf_datapath.sv
// Datapath: registers, shared multiplier, divider, accumulators and result register.
module sphf_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sphf_pkg::cmd_t          cmd,
	output sphf_pkg::status_t       status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [30:0]             cfg_data,
	input  logic                    opcode,
	input  logic signed [31:0]      pressure,
	input  logic [30:0]             density,
	input  logic signed [31:0]      vel_x,
	input  logic signed [31:0]      vel_y,
	input  logic signed [31:0]      to_other_x,
	input  logic signed [31:0]      to_other_y,
	input  logic [30:0]             distance,
	input  logic signed [31:0]      grad_x,
	input  logic signed [31:0]      grad_y,
	input  logic                    last,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [31:0]      force_x,
	output logic signed [31:0]      force_y
);
	import sphf_pkg::*;

	// Configuration registers.
	logic [30:0] mass_q, support_q, visc_q;

	// Particle state.
	logic signed [31:0] own_p_q, own_vx_q, own_vy_q;
	logic [30:0]        own_d_q;
	logic signed [47:0] sum_x_q, sum_y_q;

	// Captured item.
	logic               op_q, last_q;
	logic signed [31:0] p_q, rx_q, ry_q, gx_q, gy_q, vx_q, vy_q, dvx_q, dvy_q;
	logic [30:0]        rho_q, dist_q;

	// Working registers.
	logic signed [31:0] coef_q, tmp_q, dot_q, mu_q, fx_q;
	logic [31:0]        den_q;
	logic [PROD_W-1:0]  prod_q, pl_q;
	logic               mneg_q;

	// Result register.
	logic               rvalid_q;
	logic signed [31:0] force_x_q, force_y_q;

	logic [31:0]        ma, mb;
	logic               mneg;
	logic [47:0]        smx, smy;
	logic signed [31:0] smul_res;
	logic signed [31:0] quot;
	logic               div_done;
	logic signed [31:0] div_num;
	logic [DIV_W-1:0]   div_den;
	logic [DIV_W-1:0]   sq;
	logic [31:0]        dsum;
	logic [30:0]        avg;
	logic signed [31:0] den_sat;
	logic [95:0]        pfull;
	logic [30:0]        rm;
	logic signed [31:0] fcalc;
	logic               out_take;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q    <= MASS_RST;
			support_q <= SUPPORT_RST;
			visc_q    <= VISC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MASS:    mass_q    <= cfg_data;
				CFG_SUPPORT: support_q <= cfg_data;
				CFG_VISC:    visc_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier operand selection on magnitudes.
	assign smx = mag48(sum_x_q);
	assign smy = mag48(sum_y_q);

	always_comb begin
		ma   = '0;
		mb   = '0;
		mneg = 1'b0;
		unique case (cmd.mul)
			MS_NONE: ;
			MS_SQ: begin
				ma = {1'b0, rho_q};
				mb = {1'b0, rho_q};
			end
			MS_CGX: begin
				ma = mag32(coef_q); mb = mag32(gx_q); mneg = coef_q[31] ^ gx_q[31];
			end
			MS_CGY: begin
				ma = mag32(coef_q); mb = mag32(gy_q); mneg = coef_q[31] ^ gy_q[31];
			end
			MS_RDX: begin
				ma = mag32(rx_q); mb = mag32(dvx_q); mneg = rx_q[31] ^ dvx_q[31];
			end
			MS_RDY: begin
				ma = mag32(ry_q); mb = mag32(dvy_q); mneg = ry_q[31] ^ dvy_q[31];
			end
			MS_HH: begin
				ma = {1'b0, support_q}; mb = {1'b0, support_q};
			end
			MS_TC: begin
				ma = mag32(tmp_q); mb = C001; mneg = tmp_q[31];
			end
			MS_HD: begin
				ma = {1'b0, support_q}; mb = mag32(dot_q); mneg = dot_q[31];
			end
			MS_MM: begin
				ma = mag32(mu_q); mb = mag32(mu_q);
			end
			MS_VM: begin
				ma = {1'b0, visc_q}; mb = mag32(mu_q); mneg = mu_q[31];
			end
			MS_M2: begin
				ma = {1'b0, mass_q}; mb = {1'b0, mass_q};
			end
			MS_SXL: begin
				ma = mag32(tmp_q); mb = smx[31:0]; mneg = tmp_q[31] ^ sum_x_q[47];
			end
			MS_SXH: begin
				ma = mag32(tmp_q); mb = {16'd0, smx[47:32]};
				mneg = tmp_q[31] ^ sum_x_q[47];
			end
			MS_SYL: begin
				ma = mag32(tmp_q); mb = smy[31:0]; mneg = tmp_q[31] ^ sum_y_q[47];
			end
			MS_SYH: begin
				ma = mag32(tmp_q); mb = {16'd0, smy[47:32]};
				mneg = tmp_q[31] ^ sum_y_q[47];
			end
			default: ;
		endcase
	end

	// Registered 32 by 32 product.
	always_ff @(posedge clk) begin
		if (cmd.mul != MS_NONE) begin
			prod_q <= ma * mb;
			mneg_q <= mneg;
		end
	end

	// Signed Q product, saturated.
	assign smul_res = sat_mag({32'd0, prod_q[PROD_W-1:FRAC_BITS]}, mneg_q);

	// Divider operands.
	assign sq   = (prod_q[PROD_W-1:FRAC_BITS] == '0) ? DIV_W'(1) :
		prod_q[PROD_W-1:FRAC_BITS];
	assign dsum = {1'b0, own_d_q} + {1'b0, rho_q};
	assign avg  = (dsum[31:1] == '0) ? 31'd1 : dsum[31:1];

	always_comb begin
		div_num = tmp_q;
		div_den = {16'd0, den_q};
		unique case (cmd.div)
			DS_NONE: ;
			DS_P: begin
				div_num = p_q;
				div_den = sq;
			end
			DS_MU: begin
				div_num = tmp_q;
				div_den = {16'd0, den_q};
			end
			DS_FAC: begin
				div_num = tmp_q;
				div_den = {17'd0, avg};
			end
			default: ;
		endcase
	end

	sphf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div != DS_NONE),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// Viscosity denominator, never below one LSB.
	assign den_sat = sat33({2'b00, dist_q} + {smul_res[31], smul_res});

	// Final force: negated M squared times the sum, saturated.
	assign pfull = {prod_q[63:0], 32'd0} + {32'd0, pl_q};
	assign rm    = (|pfull[95:47]) ? {31{1'b1}} : pfull[46:16];
	assign fcalc = mneg_q ? $signed({1'b0, rm}) : -$signed({1'b0, rm});

	// Working registers and captured item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			last_q <= last;
			p_q    <= pressure;
			rho_q  <= (density == '0) ? 31'd1 : density;
			vx_q   <= vel_x;
			vy_q   <= vel_y;
			rx_q   <= to_other_x;
			ry_q   <= to_other_y;
			dist_q <= distance;
			gx_q   <= grad_x;
			gy_q   <= grad_y;
			dvx_q  <= sat33({vel_x[31], vel_x} - {own_vx_q[31], own_vx_q});
			dvy_q  <= sat33({vel_y[31], vel_y} - {own_vy_q[31], own_vy_q});
		end
		unique case (cmd.wb)
			WB_PB:  coef_q <= sat33({own_p_q[31], own_p_q} + {quot[31], quot});
			WB_DX:  tmp_q  <= smul_res;
			WB_DY:  dot_q  <= sat33({tmp_q[31], tmp_q} + {smul_res[31], smul_res});
			WB_HH:  tmp_q  <= smul_res;
			WB_DEN: den_q  <= (den_sat < 1) ? 32'd1 : den_sat;
			WB_HD:  tmp_q  <= smul_res;
			WB_MU:  mu_q   <= quot;
			WB_MM:  tmp_q  <= sat33({smul_res, 1'b0});
			WB_VM:  tmp_q  <= sat33({tmp_q[31], tmp_q} - {smul_res[31], smul_res});
			WB_FAC: coef_q <= quot;
			WB_M2:  tmp_q  <= smul_res;
			WB_PL:  pl_q   <= prod_q;
			WB_FX:  fx_q   <= fcalc;
			default: ;
		endcase
	end

	// Particle state and sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_p_q  <= '0;
			own_d_q  <= '0;
			own_vx_q <= '0;
			own_vy_q <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
		end else begin
			unique case (cmd.wb)
				WB_OWN: begin
					own_p_q  <= quot;
					own_d_q  <= rho_q;
					own_vx_q <= vx_q;
					own_vy_q <= vy_q;
					sum_x_q  <= '0;
					sum_y_q  <= '0;
				end
				WB_SX: sum_x_q <= sat49({sum_x_q[47], sum_x_q} +
					{{17{smul_res[31]}}, smul_res});
				WB_SY: sum_y_q <= sat49({sum_y_q[47], sum_y_q} +
					{{17{smul_res[31]}}, smul_res});
				WB_FY: begin
					sum_x_q <= '0;
					sum_y_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Result register, free to take a new item once the old one is gone.
	assign out_take = rvalid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (cmd.wb == WB_FY) begin
			rvalid_q <= 1'b1;
		end else if (out_take) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb == WB_FY) begin
			force_x_q <= fx_q;
			force_y_q <= fcalc;
		end
	end

	assign result_valid = rvalid_q;
	assign force_x      = force_x_q;
	assign force_y      = force_y_q;

	assign status.opcode   = op_q;
	assign status.last     = last_q;
	assign status.dot_neg  = dot_q[31];
	assign status.div_done = div_done;
	assign status.out_busy = rvalid_q && result_stall;

endmodule

>>> sv/sphf_ctrl.sv
// Controller: state machine that sequences the datapath for one item.
module sphf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sphf_pkg::status_t status,
	output sphf_pkg::cmd_t    cmd
);
	import sphf_pkg::*;

	state_t state_q, state_d;
	logic   vpass_q, vpass_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vpass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vpass_q <= vpass_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		vpass_d  = vpass_q;
		cmd.load = 1'b0;
		cmd.mul  = MS_NONE;
		cmd.div  = DS_NONE;
		cmd.wb   = WB_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					vpass_d  = 1'b0;
					state_d  = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: begin cmd.mul = MS_SQ; state_d = ST_P_DIV; end
			ST_P_DIV:  begin cmd.div = DS_P; state_d = ST_P_WAIT; end
			ST_P_WAIT: begin
				if (status.div_done) begin
					if (status.opcode == OP_BEGIN) begin
						cmd.wb  = WB_OWN;
						state_d = ST_IDLE;
					end else begin
						cmd.wb  = WB_PB;
						state_d = ST_GX_MUL;
					end
				end
			end
			ST_GX_MUL: begin cmd.mul = MS_CGX; state_d = ST_GX_WB; end
			ST_GX_WB:  begin cmd.wb = WB_SX; state_d = ST_GY_MUL; end
			ST_GY_MUL: begin cmd.mul = MS_CGY; state_d = ST_GY_WB; end
			ST_GY_WB: begin
				cmd.wb  = WB_SY;
				state_d = vpass_q ? ST_END : ST_DX_MUL;
			end
			ST_DX_MUL: begin cmd.mul = MS_RDX; state_d = ST_DX_WB; end
			ST_DX_WB:  begin cmd.wb = WB_DX; state_d = ST_DY_MUL; end
			ST_DY_MUL: begin cmd.mul = MS_RDY; state_d = ST_DY_WB; end
			ST_DY_WB:  begin cmd.wb = WB_DY; state_d = ST_DOT; end
			ST_DOT:    state_d = status.dot_neg ? ST_HH_MUL : ST_END;
			ST_HH_MUL: begin cmd.mul = MS_HH; state_d = ST_HH_WB; end
			ST_HH_WB:  begin cmd.wb = WB_HH; state_d = ST_C_MUL; end
			ST_C_MUL:  begin cmd.mul = MS_TC; state_d = ST_C_WB; end
			ST_C_WB:   begin cmd.wb = WB_DEN; state_d = ST_HD_MUL; end
			ST_HD_MUL: begin cmd.mul = MS_HD; state_d = ST_HD_WB; end
			ST_HD_WB:  begin cmd.wb = WB_HD; state_d = ST_MU_DIV; end
			ST_MU_DIV: begin cmd.div = DS_MU; state_d = ST_MU_WAIT; end
			ST_MU_WAIT: begin
				if (status.div_done) begin
					cmd.wb  = WB_MU;
					state_d = ST_MM_MUL;
				end
			end
			ST_MM_MUL: begin cmd.mul = MS_MM; state_d = ST_MM_WB; end
			ST_MM_WB:  begin cmd.wb = WB_MM; state_d = ST_VM_MUL; end
			ST_VM_MUL: begin cmd.mul = MS_VM; state_d = ST_VM_WB; end
			ST_VM_WB:  begin cmd.wb = WB_VM; state_d = ST_FAC_DIV; end
			ST_FAC_DIV: begin cmd.div = DS_FAC; state_d = ST_FAC_WAIT; end
			ST_FAC_WAIT: begin
				// The viscosity factor reuses the gradient accumulation steps.
				if (status.div_done) begin
					cmd.wb  = WB_FAC;
					vpass_d = 1'b1;
					state_d = ST_GX_MUL;
				end
			end
			ST_END:     state_d = status.last ? ST_M2_MUL : ST_IDLE;
			ST_M2_MUL:  begin cmd.mul = MS_M2; state_d = ST_M2_WB; end
			ST_M2_WB:   begin cmd.wb = WB_M2; state_d = ST_SXL_MUL; end
			ST_SXL_MUL: begin cmd.mul = MS_SXL; state_d = ST_SXL_WB; end
			ST_SXL_WB:  begin cmd.wb = WB_PL; state_d = ST_SXH_MUL; end
			ST_SXH_MUL: begin cmd.mul = MS_SXH; state_d = ST_SXH_WB; end
			ST_SXH_WB:  begin cmd.wb = WB_FX; state_d = ST_SYL_MUL; end
			ST_SYL_MUL: begin cmd.mul = MS_SYL; state_d = ST_SYL_WB; end
			ST_SYL_WB:  begin cmd.wb = WB_PL; state_d = ST_SYH_MUL; end
			ST_SYH_MUL: begin cmd.mul = MS_SYH; state_d = ST_SYH_WB; end
			ST_SYH_WB: begin
				// Hold until the result register is free.
				if (!status.out_busy) begin
					cmd.wb  = WB_FY;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

>>> sv/sph_pressure_viscosity_force_unit.sv
// Top level of the SPH pressure force unit with artificial viscosity.
//
// Input items arrive on item_valid/item_stall; an item is taken at a clock
// edge with item_valid high and item_stall low. A begin item (opcode 0)
// loads the particle's own values and clears the sums; neighbor items
// (opcode 1) accumulate pressure and viscosity terms. The neighbor item with
// last set produces one force increment on result_valid/result_stall.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// and cfg_ready is always high.
// One item is worked on at a time. A neighbor item does more work when the
// viscosity term applies and on the last item. The 48-step shared divider is
// used up to three times per item, and the shared multiplier registers each
// product. A finished result waits in an output register, so the next item
// is taken while result_stall is high; only a further result waits. Reset
// clears the own values, the sums and the result valid flag, and restores
// the register defaults.
module sph_pressure_viscosity_force_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic signed [31:0] pressure,
	input  logic [30:0]        density,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] to_other_x,
	input  logic signed [31:0] to_other_y,
	input  logic [30:0]        distance,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y
);
	import sphf_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	sphf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Arithmetic and storage.
	sphf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.pressure     (pressure),
		.density      (density),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.to_other_x   (to_other_x),
		.to_other_y   (to_other_y),
		.distance     (distance),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.force_x      (force_x),
		.force_y      (force_y)
	);

endmodule
